// ----- rtl/uqsd_pkg.sv -----
// Shared types and constants for the URL query stream decoder.
`timescale 1ns / 1ps

package uqsd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_PAIR  = 2'd2;

  // Input commands
  localparam logic CMD_BYTE   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Characters with a special meaning in a query string
  localparam logic [7:0] CH_EQUAL = 8'h3D;  // '='
  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

  // Escape sequencer, one-hot
  typedef enum logic [2:0] {
    ESC_IDLE   = 3'b001,
    ESC_FIRST  = 3'b010,
    ESC_SECOND = 3'b100
  } esc_state_t;

  // Contents of the input register
  typedef struct packed {
    logic       valid;
    logic       command;
    logic [7:0] data_byte;
  } in_stage_t;

  // Outcome of one escape pair
  typedef struct packed {
    logic       emit;
    logic [7:0] value;
  } esc_result_t;

endpackage

// ----- rtl/uqsd_if.sv -----
// Channel interfaces for the input bytes and the decoded results.
`timescale 1ns / 1ps

interface uqsd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface uqsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] decoded_byte;

  modport source (output valid, output kind, output decoded_byte, input ready);
  modport sink (input valid, input kind, input decoded_byte, output ready);
endinterface

// ----- rtl/uqsd_esc_decode.sv -----
// Two-character percent escape parser with base-16 string conversion rules.
`timescale 1ns / 1ps

module uqsd_esc_decode import uqsd_pkg::*; (
  input  logic [7:0]  first_char,
  input  logic [7:0]  second_char,
  output esc_result_t result
);

  function automatic logic is_hex(input logic [7:0] ch);
    return ch inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] ch);
    logic [3:0] v;
    v = 4'd0;
    if (ch inside {[8'h30:8'h39]}) begin
      v = 4'(ch - 8'h30);
    end else if (ch inside {[8'h41:8'h46]}) begin
      v = 4'(ch - 8'h37);
    end else if (ch inside {[8'h61:8'h66]}) begin
      v = 4'(ch - 8'h57);
    end
    return v;
  endfunction

  function automatic logic is_ws(input logic [7:0] ch);
    return ch inside {CH_SPACE, [8'h09:8'h0D]};
  endfunction

  logic [3:0] h0;
  logic [3:0] h1;
  logic       hex0;
  logic       hex1;
  logic [7:0] value;

  assign h0   = hex_val(first_char);
  assign h1   = hex_val(second_char);
  assign hex0 = is_hex(first_char);
  assign hex1 = is_hex(second_char);

  // Leading whitespace or '+' shifts the digits; a sign or a second skip
  // character leaves no digits, which reads as zero.
  always_comb begin
    value = 8'd0;
    if (hex0) begin
      value = hex1 ? {h0, h1} : {4'd0, h0};
    end else if (is_ws(first_char) || first_char == CH_PLUS) begin
      value = hex1 ? {4'd0, h1} : 8'd0;
    end
  end

  assign result.emit  = (value != 8'd0);
  assign result.value = value;

endmodule

// ----- rtl/uqsd_core.sv -----
// Query parser state, escape handling and result register.
`timescale 1ns / 1ps

module uqsd_core import uqsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_stage_t  stage,
  input  logic       out_ready,
  output logic       stage_take,
  output logic       out_valid,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte
);

  esc_state_t  esc_r, esc_nxt;
  logic        in_key_r, in_key_nxt;
  logic        key_ne_r, key_ne_nxt;
  logic [7:0]  first_hex_r, first_hex_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;

  logic        out_free;
  logic        fire;
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [7:0]  res_byte;
  esc_result_t esc_res;

  uqsd_esc_decode u_esc (
    .first_char  (first_hex_r),
    .second_char (stage.data_byte),
    .result      (esc_res)
  );

  assign out_free   = !out_valid_r || out_ready;
  assign stage_take = out_free;
  assign fire       = stage.valid && out_free;

  always_comb begin
    esc_nxt       = esc_r;
    in_key_nxt    = in_key_r;
    key_ne_nxt    = key_ne_r;
    first_hex_nxt = first_hex_r;
    res_valid     = 1'b0;
    res_kind      = in_key_r ? KIND_KEY : KIND_VALUE;
    res_byte      = stage.data_byte;

    if (stage.command == CMD_FINISH) begin
      if (key_ne_r) begin
        key_ne_nxt = 1'b0;
        res_valid  = 1'b1;
        res_kind   = KIND_PAIR;
        res_byte   = 8'd0;
      end
    end else begin
      case (esc_r)
        ESC_IDLE: begin
          if (in_key_r && stage.data_byte == CH_EQUAL) begin
            in_key_nxt = 1'b0;
          end else if (!in_key_r && stage.data_byte == CH_AMP) begin
            in_key_nxt = 1'b1;
            key_ne_nxt = 1'b0;
            res_valid  = 1'b1;
            res_kind   = KIND_PAIR;
            res_byte   = 8'd0;
          end else if (stage.data_byte == CH_PCT) begin
            esc_nxt = ESC_FIRST;
          end else begin
            res_valid = 1'b1;
            if (stage.data_byte == CH_PLUS) begin
              res_byte = CH_SPACE;
            end
          end
        end
        ESC_FIRST: begin
          first_hex_nxt = stage.data_byte;
          esc_nxt       = ESC_SECOND;
        end
        ESC_SECOND: begin
          esc_nxt   = ESC_IDLE;
          res_valid = esc_res.emit;
          res_byte  = esc_res.value;
        end
        default: begin
          esc_nxt = ESC_IDLE;
        end
      endcase
      if (res_valid && in_key_r && res_kind == KIND_KEY) begin
        key_ne_nxt = 1'b1;
      end
    end

    if (!fire) begin
      esc_nxt       = esc_r;
      in_key_nxt    = in_key_r;
      key_ne_nxt    = key_ne_r;
      first_hex_nxt = first_hex_r;
    end

    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    if (out_free) begin
      out_valid_nxt = fire && res_valid;
      out_kind_nxt  = res_kind;
      out_byte_nxt  = res_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r       <= ESC_IDLE;
      in_key_r    <= 1'b1;
      key_ne_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      esc_r       <= esc_nxt;
      in_key_r    <= in_key_nxt;
      key_ne_r    <= key_ne_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_hex_r <= first_hex_nxt;
    out_kind_r  <= out_kind_nxt;
    out_byte_r  <= out_byte_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;

endmodule

// ----- rtl/url_query_stream_decoder.sv -----
// Top level of the streaming URL query-string decoder.
`timescale 1ns / 1ps
//
//  Channel   Dir   Payload                         Transfer
//  in_ch     in    command[0], data_byte[7:0]      valid && ready
//  out_ch    out   kind[1:0], decoded_byte[7:0]    valid && ready
//
//  A byte lands in the input register, is parsed in one pass and its result
//  (if any) lands in the result register; a new transfer can be taken every
//  cycle while out_ch does not stall.
//  Reset (rst_n low, synchronous) returns to key collection, no escape
//  pending, empty key, both registers empty.
//  A stall on out_ch holds the result register and then the input register;
//  in_ch.ready drops only when both are full.

module url_query_stream_decoder import uqsd_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  uqsd_in_if.sink        in_ch,
  uqsd_out_if.source     out_ch
);

  in_stage_t s1_r, s1_nxt;
  logic      stage_take;
  logic      in_xfer;

  // Take a new byte when the input register is empty or drains this cycle.
  assign in_ch.ready = !s1_r.valid || stage_take;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_nxt = s1_r;
    if (stage_take) begin
      s1_nxt.valid = 1'b0;
    end
    if (in_xfer) begin
      s1_nxt.valid     = 1'b1;
      s1_nxt.command   = in_ch.command;
      s1_nxt.data_byte = in_ch.data_byte;
    end
  end

  // Clear only the valid bit on reset; the payload of the input register
  // needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r.valid <= s1_nxt.valid;
    end
    s1_r.command   <= s1_nxt.command;
    s1_r.data_byte <= s1_nxt.data_byte;
  end

  uqsd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (s1_r),
    .out_ready  (out_ch.ready),
    .stage_take (stage_take),
    .out_valid  (out_ch.valid),
    .out_kind   (out_ch.kind),
    .out_byte   (out_ch.decoded_byte)
  );

`ifndef NO_ASSERTIONS
  // A pair marker never carries a character.
  a_pair_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_PAIR) |-> (out_ch.decoded_byte == 8'd0))
    else $error("pair marker with nonzero byte");

  // Backpressure on the input only while a byte waits in the input register.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_r.valid)
    else $error("input stalled with empty input register");

  // A stalled input register keeps its byte.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_r.valid && !stage_take) |=> (s1_r.valid && $stable(s1_r.data_byte)
      && $stable(s1_r.command)))
    else $error("input register lost a stalled byte");

  // The result register only changes once the consumer took it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !stage_take)
    else $error("result stage advanced under stall");
`endif

endmodule

// ----- tb/url_query_stream_decoder_tb.sv -----
// Self-checking testbench for the streaming URL query-string decoder.
`timescale 1ns / 1ps

module url_query_stream_decoder_tb import uqsd_pkg::*;;

  // One query byte or finish command waiting to be offered to the block.
  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    bit         drain_first;  // hold this transfer until every result is back
  } query_item_t;

  // One decoded result that the block owes us.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] decoded_byte;
  } decoded_t;

  localparam int RANDOM_ITEMS = 600;
  localparam int CALM_ITEMS   = 100;  // no idling over the last transfers
  localparam int BIG_STALL_AT = 150;  // transfers accepted before the long hold-off
  localparam int BIG_STALL    = 120;  // cycles of the long hold-off
  localparam int DRAIN_AT     = 350;  // index of the item that waits for a drain
  localparam int SETTLE       = 20;

  logic clk;
  logic rst_n;

  uqsd_in_if  in_ch ();
  uqsd_out_if out_ch ();

  url_query_stream_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  query_item_t query_q[$];
  decoded_t    decoded_q[$];

  int  stim_total;
  int  sent_count;
  int  send_gap;
  int  recv_stall;
  bit  big_stall_done;
  int  mismatch_count;
  logic calm;

  // Decoder state as we expect it inside the block.
  bit         collecting_key;
  esc_state_t esc_phase;
  logic [7:0] first_char;
  bit         key_seen;

  assign calm = (stim_total > 0) && (sent_count + CALM_ITEMS >= stim_total);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Interpret two escape characters the way a base-16 string conversion would:
  // skip leading whitespace, take one optional sign, stop at the first non-hex
  // character or a zero byte. Zero and negative values emit nothing.
  function automatic esc_result_t escape_value(input logic [7:0] c0, input logic [7:0] c1);
    logic [7:0]  s [2];
    int          i;
    int          val;
    int          digit;
    bit          neg;
    esc_result_t r;
    s[0] = c0;
    s[1] = c1;
    i = 0;
    val = 0;
    neg = 1'b0;
    while (i < 2 && s[i] != 8'h00 && (s[i] == CH_SPACE || (s[i] >= 8'd9 && s[i] <= 8'd13)))
      i++;
    if (i < 2 && s[i] == CH_PLUS) begin
      i++;
    end else if (i < 2 && s[i] == "-") begin
      neg = 1'b1;
      i++;
    end
    while (i < 2 && s[i] != 8'h00) begin
      if (s[i] >= "0" && s[i] <= "9") digit = s[i] - "0";
      else if (s[i] >= "a" && s[i] <= "f") digit = s[i] - "a" + 10;
      else if (s[i] >= "A" && s[i] <= "F") digit = s[i] - "A" + 10;
      else break;
      val = val * 16 + digit;
      i++;
    end
    r.emit  = !neg && val != 0 && val <= 255;
    r.value = val[7:0];
    return r;
  endfunction

  // Advance the expected decoder state by one accepted transfer and queue
  // the result it produces, if any.
  task automatic decode_transfer(input logic command, input logic [7:0] ch);
    esc_result_t er;
    logic [7:0]  c;
    bit          emit;
    c = ch;
    emit = 1'b1;
    if (command == CMD_FINISH) begin
      // Finish closes the pair only when a key byte went out; key/escape
      // collection state is left as it is.
      if (key_seen) begin
        key_seen = 1'b0;
        decoded_q.push_back('{kind: KIND_PAIR, decoded_byte: 8'h00});
      end
      return;
    end
    // Separators count only outside an escape.
    if (esc_phase == ESC_IDLE) begin
      if (collecting_key && ch == CH_EQUAL) begin
        collecting_key = 1'b0;
        return;
      end
      if (!collecting_key && ch == CH_AMP) begin
        collecting_key = 1'b1;
        key_seen = 1'b0;
        decoded_q.push_back('{kind: KIND_PAIR, decoded_byte: 8'h00});
        return;
      end
    end
    case (esc_phase)
      ESC_FIRST: begin
        first_char = ch;
        esc_phase = ESC_SECOND;
        emit = 1'b0;
      end
      ESC_SECOND: begin
        esc_phase = ESC_IDLE;
        er = escape_value(first_char, ch);
        emit = er.emit;
        c = er.value;
      end
      default: begin
        if (ch == CH_PLUS) begin
          c = CH_SPACE;
        end else if (ch == CH_PCT) begin
          esc_phase = ESC_FIRST;
          emit = 1'b0;
        end
      end
    endcase
    if (emit) begin
      if (collecting_key) begin
        key_seen = 1'b1;
        decoded_q.push_back('{kind: KIND_KEY, decoded_byte: c});
      end else begin
        decoded_q.push_back('{kind: KIND_VALUE, decoded_byte: c});
      end
    end
  endtask

  task automatic add_item(input logic command, input logic [7:0] ch);
    query_q.push_back('{command: command, data_byte: ch, drain_first: 1'b0});
  endtask

  // Mostly hex digits, with whitespace, signs, zero bytes and noise mixed in.
  function automatic logic [7:0] pick_escape_char();
    string hex_chars;
    int    r;
    hex_chars = "0123456789abcdefABCDEF";
    r = $urandom_range(0, 9);
    if (r <= 5) return hex_chars[$urandom_range(0, 21)];
    if (r == 6) return ($urandom_range(0, 1) != 0) ? CH_SPACE : 8'($urandom_range(9, 13));
    if (r == 7) return ($urandom_range(0, 1) != 0) ? CH_PLUS : "-";
    if (r == 8) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Driver: offer queued items, hold each until its transfer, and feed every
  // transfer to the prediction. Gaps come in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.command   <= CMD_BYTE;
      in_ch.data_byte <= 8'h00;
      send_gap        <= 0;
      sent_count      <= 0;
    end else begin : drive_query
      query_item_t item;
      if (in_ch.valid && in_ch.ready) begin
        decode_transfer(in_ch.command, in_ch.data_byte);
        sent_count <= sent_count + 1;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered item until the block takes it
      end else if (send_gap > 0) begin
        send_gap    <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (query_q.size() == 0 ||
                   (query_q[0].drain_first && decoded_q.size() != 0)) begin
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        // go idle and load a random gap length into send_gap
        send_gap    <= $urandom_range(0, 13);
        in_ch.valid <= 1'b0;
      end else begin
        item = query_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.command   <= item.command;
        in_ch.data_byte <= item.data_byte;
      end
    end
  end

  // Receiver ready: random stall bursts, plus one long hold-off that lets
  // the block fill up and push back on its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready   <= 1'b0;
      recv_stall     <= 0;
      big_stall_done <= 1'b0;
    end else if (!big_stall_done && sent_count >= BIG_STALL_AT) begin
      big_stall_done <= 1'b1;
      recv_stall     <= BIG_STALL - 1;
      out_ch.ready   <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall   <= recv_stall - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      recv_stall   <= $urandom_range(0, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: compare every result transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    decoded_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: kind %0d decoded_byte 0x%02h",
               out_ch.kind, out_ch.decoded_byte);
        mismatch_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_ch.kind);
          mismatch_count++;
        end
        if (out_ch.decoded_byte !== want.decoded_byte) begin
          $error("decoded_byte: expected 0x%02h, actual 0x%02h",
                 want.decoded_byte, out_ch.decoded_byte);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int r;
    int directed_count;
    rst_n           = 1'b0;
    stim_total      = 0;
    mismatch_count  = 0;
    collecting_key  = 1'b1;
    esc_phase       = ESC_IDLE;
    first_char      = 8'h00;
    key_seen        = 1'b0;

    // Directed part.
    add_item(CMD_FINISH, 8'h00);                 // finish on an empty key: nothing
    add_item(CMD_BYTE, "k");
    add_item(CMD_BYTE, CH_PLUS);                 // plus turns into a space
    add_item(CMD_BYTE, 8'hFF);
    add_item(CMD_BYTE, CH_PCT);                  // escape decoding to '+', kept as is
    add_item(CMD_BYTE, "2");
    add_item(CMD_BYTE, "B");
    add_item(CMD_BYTE, CH_EQUAL);                // switch to the value
    add_item(CMD_BYTE, CH_PCT);                  // separators inside an escape are escape characters
    add_item(CMD_BYTE, CH_EQUAL);
    add_item(CMD_BYTE, CH_AMP);
    add_item(CMD_BYTE, CH_PCT);                  // leading whitespace skipped
    add_item(CMD_BYTE, CH_SPACE);
    add_item(CMD_BYTE, "7");
    add_item(CMD_BYTE, CH_PCT);                  // negative escape emits nothing
    add_item(CMD_BYTE, "-");
    add_item(CMD_BYTE, "1");
    add_item(CMD_BYTE, CH_PCT);                  // largest escape value
    add_item(CMD_BYTE, "f");
    add_item(CMD_BYTE, "F");
    add_item(CMD_BYTE, 8'h00);
    add_item(CMD_BYTE, CH_AMP);                  // end the pair
    add_item(CMD_BYTE, "x");
    add_item(CMD_FINISH, 8'hFF);                 // finish with a key: pair end
    add_item(CMD_FINISH, 8'h00);                 // second finish: nothing
    add_item(CMD_BYTE, CH_EQUAL);
    add_item(CMD_BYTE, CH_AMP);                  // pair end with an empty key
    directed_count = query_q.size();

    // Random part: mostly well-formed pairs with random content, some noise.
    while (query_q.size() < directed_count + RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r <= 8) begin
        add_item(CMD_BYTE, ($urandom_range(0, 3) == 0) ? 8'("0" + $urandom_range(0, 9))
                                                       : 8'("a" + $urandom_range(0, 25)));
      end else if (r == 9) begin
        add_item(CMD_BYTE, CH_PLUS);
      end else if (r <= 11) begin
        add_item(CMD_BYTE, CH_EQUAL);
      end else if (r <= 13) begin
        add_item(CMD_BYTE, CH_AMP);
      end else if (r <= 16) begin
        add_item(CMD_BYTE, CH_PCT);
        add_item(CMD_BYTE, pick_escape_char());
        add_item(CMD_BYTE, pick_escape_char());
      end else if (r == 17) begin
        add_item(CMD_FINISH, 8'($urandom_range(0, 255)));
      end else begin
        add_item(CMD_BYTE, 8'($urandom_range(0, 255)));
      end
    end
    query_q[DRAIN_AT].drain_first = 1'b1;
    stim_total = query_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (query_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (decoded_q.size() != 0) begin
      $error("%0d expected results never arrived", decoded_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
